/* rtl/sseg_pkg.sv */
`default_nettype none

package sseg_pkg;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_REFRESH_PERIOD = 2'd0,
    REG_SCROLL_PERIOD  = 2'd1,
    REG_MESSAGE_TEXT   = 2'd2
  } reg_index_t;

  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned MSG_BYTES   = 8;

  localparam logic [15:0] REFRESH_PERIOD_RST = 16'd2;
  localparam logic [15:0] SCROLL_PERIOD_RST  = 16'd250;
  // " dMA    ", first character in the low byte
  localparam logic [63:0] MESSAGE_TEXT_RST   = 64'h2020_2020_414D_6420;

  localparam logic [7:0] DIGIT_SEL_BASE = 8'hF0;
  localparam logic [7:0] GLYPH_BLANK    = 8'h00;
  localparam logic [7:0] CHAR_E         = 8'h45;

  // ASCII to seven-segment code, bit0 = a .. bit6 = g. No glyph -> blank.
  function automatic logic [7:0] glyph(input logic [7:0] ch);
    logic [7:0] c;
    logic [7:0] g;
    c = ch;
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      c = ch - 8'h20;
    end
    case (c)
      8'h30, 8'h4F: g = 8'h3F;   // 0 O
      8'h31, 8'h49: g = 8'h06;   // 1 I
      8'h32, 8'h5A: g = 8'h5B;   // 2 Z
      8'h33:        g = 8'h4F;
      8'h34:        g = 8'h66;
      8'h35, 8'h53: g = 8'h6D;   // 5 S
      8'h36:        g = 8'h7D;
      8'h37:        g = 8'h07;
      8'h38, 8'h42: g = 8'h7F;   // 8 B
      8'h39:        g = 8'h6F;
      8'h41:        g = 8'h77;   // A
      8'h43:        g = 8'h39;   // C
      8'h44:        g = 8'h5E;   // D
      8'h45:        g = 8'h79;   // E
      8'h46:        g = 8'h71;   // F
      8'h48:        g = 8'h76;   // H
      8'h4C:        g = 8'h38;   // L
      8'h4D:        g = 8'h37;   // M
      8'h4E:        g = 8'h54;   // N
      8'h50:        g = 8'h73;   // P
      8'h52:        g = 8'h50;   // R
      8'h54:        g = 8'h78;   // T
      8'h55:        g = 8'h3E;   // U
      8'h59:        g = 8'h6E;   // Y
      8'h2D:        g = 8'h40;   // -
      8'h5F:        g = 8'h08;   // _
      default:      g = GLYPH_BLANK;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

/* rtl/sseg_if.sv */
`default_nettype none

// Tick channel: one item per millisecond tick
interface sseg_tick_if;
  logic valid;
  logic ready;
  logic copy_fault;

  modport source (output valid, output copy_fault, input ready);
  modport sink   (input valid, input copy_fault, output ready);
endinterface

// Frame channel: one display frame
interface sseg_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] segments_active_low;
  logic [7:0] digit_select;
  logic       error_mode;

  modport source (output valid, output segments_active_low, output digit_select,
                  output error_mode, input ready);
  modport sink   (input valid, input segments_active_low, input digit_select,
                  input error_mode, output ready);
endinterface

`default_nettype wire

/* rtl/scrolling_seven_segment_scanner_unit.sv */
`default_nettype none

// Scrolling seven-segment scanner.
// tick  (sink):   one transfer per millisecond tick, payload copy_fault.
// frame (source): one display frame (active-low segment byte, digit select,
//                 error flag) each time the refresh counter expires.
// cfg_*:          register writes (refresh period, scroll period, message),
//                 applied at the edge where cfg_wr_en is high; issue only
//                 while idle.
// Output: a frame is registered in the output or, when stuck, skid register.
// Throughput: one tick per cycle while tick.ready is high. The state update
//   (two 16-bit counters, digit and offset counters) is a single registered step per tick.
// Stall: frames go into an output register backed by one skid register, so
//   ticks keep being taken while one frame waits; tick.ready drops only when
//   both hold a frame, and returns the cycle after frame drains one.
// Reset (rst, synchronous): counters, scan digit, scroll offset and error
//   latch clear; registers return to 2 ms, 250 ms and " dMA    ";
//   both frame slots empty.
// A copy_fault on a tick that emits a frame latches error mode: every later
//   frame shows 'E' until reset.
module scrolling_seven_segment_scanner_unit
  import sseg_pkg::*;
#(
  parameter int unsigned NUM_DIGITS     = 4,
  parameter int unsigned MESSAGE_LENGTH = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  sseg_tick_if.sink                  tick,
  sseg_frame_if.source               frame
);

  localparam int unsigned DIG_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int unsigned OFS_W = (MESSAGE_LENGTH > 1) ? $clog2(MESSAGE_LENGTH) : 1;
  localparam logic [DIG_W-1:0] DIG_LAST = DIG_W'(NUM_DIGITS - 1);
  localparam logic [OFS_W-1:0] OFS_LAST = OFS_W'(MESSAGE_LENGTH - 1);
  localparam logic [3:0]       LEN4     = 4'(MESSAGE_LENGTH);

  typedef struct packed {
    logic [7:0] seg;
    logic [7:0] sel;
    logic       err;
  } frame_t;

  // configuration registers
  logic [15:0] refresh_period;
  logic [15:0] scroll_period;
  logic [63:0] message_text;

  // scanner state
  logic [15:0]      refresh_elapsed;
  logic [15:0]      scroll_elapsed;
  logic [DIG_W-1:0] digit_idx;
  logic [OFS_W-1:0] scroll_ofs;
  logic             error_latched;

  // output register + skid
  frame_t out_reg, skid_reg;
  logic   out_valid, skid_valid;

  logic        accept, out_fire, refresh_hit, scroll_hit;
  logic [15:0] refresh_inc, scroll_inc;
  logic [3:0]  pos_sum;
  logic [2:0]  pos;
  logic [7:0]  msg_byte [MSG_BYTES];
  logic [7:0]  ch;
  frame_t      new_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_period <= REFRESH_PERIOD_RST;
      scroll_period  <= SCROLL_PERIOD_RST;
      message_text   <= MESSAGE_TEXT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_REFRESH_PERIOD: refresh_period <= cfg_data[15:0];
        REG_SCROLL_PERIOD:  scroll_period  <= cfg_data[15:0];
        REG_MESSAGE_TEXT:   message_text   <= cfg_data;
        default: ;   // unmapped index, ignored
      endcase
    end
  end

  assign tick.ready = !skid_valid;
  assign accept     = tick.valid && tick.ready;
  assign out_fire   = out_valid && frame.ready;

  // period of 0 behaves as 1 since the incremented count is always >= 0
  assign refresh_inc = refresh_elapsed + 16'd1;
  assign scroll_inc  = scroll_elapsed + 16'd1;
  assign refresh_hit = refresh_inc >= refresh_period;
  assign scroll_hit  = scroll_inc >= scroll_period;

  // message position = (offset + digit) mod length; sum < length + 4
  always_comb begin
    pos_sum = 4'(scroll_ofs) + 4'(digit_idx);
    for (int i = 0; i < 4; i++) begin
      if (pos_sum >= LEN4) begin
        pos_sum = pos_sum - LEN4;
      end
    end
    pos = pos_sum[2:0];
  end

  always_comb begin
    for (int b = 0; b < MSG_BYTES; b++) begin
      msg_byte[b] = message_text[8*b +: 8];
    end
  end

  assign ch = error_latched ? CHAR_E : msg_byte[pos];

  always_comb begin
    new_frame.seg = ~glyph(ch);
    new_frame.sel = DIGIT_SEL_BASE | (8'h01 << digit_idx);
    new_frame.err = error_latched;
  end

  // per-tick state update
  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_elapsed <= '0;
      scroll_elapsed  <= '0;
      digit_idx       <= '0;
      scroll_ofs      <= '0;
      error_latched   <= 1'b0;
    end else if (accept) begin
      if (refresh_hit) begin
        refresh_elapsed <= '0;
        digit_idx       <= (digit_idx == DIG_LAST) ? '0 : digit_idx + 1'b1;
        if (tick.copy_fault) begin
          error_latched <= 1'b1;
        end
      end else begin
        refresh_elapsed <= refresh_inc;
      end
      if (scroll_hit) begin
        scroll_elapsed <= '0;
        scroll_ofs     <= (scroll_ofs == OFS_LAST) ? '0 : scroll_ofs + 1'b1;
      end else begin
        scroll_elapsed <= scroll_inc;
      end
    end
  end

  // frame buffering: skid only fills when the output register is stuck
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (accept && refresh_hit) begin
      if (out_valid && !out_fire) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_reg <= skid_reg;
      end
    end else if (accept && refresh_hit) begin
      if (out_valid && !out_fire) begin
        skid_reg <= new_frame;
      end else begin
        out_reg <= new_frame;
      end
    end
  end

  assign frame.valid               = out_valid;
  assign frame.segments_active_low = out_reg.seg;
  assign frame.digit_select        = out_reg.sel;
  assign frame.error_mode          = out_reg.err;

endmodule

`default_nettype wire
